/* hdl/oemn_pkg.sv */
// Shared constants, types and helpers for the odd-even merge network unit.
`timescale 1ns / 1ps
`default_nettype none
package oemn_pkg;

  localparam int MAX_ITEMS = 16;
  localparam int KEY_WIDTH = 16;
  localparam int CFG_W     = 3;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int SUM_W     = ADDR_W + 3;
  localparam int LOG2_MAX  = $clog2(MAX_ITEMS + 1) - 1;

  localparam logic [CFG_W-1:0] SIZE_LOG2_RESET = CFG_W'(4);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CX_RD,
    ST_CX_CMP,
    ST_CX_WB,
    ST_EM_RD,
    ST_EM_LOAD,
    ST_EM_HOLD
  } oemn_state_t;

  typedef struct packed {
    logic load_wr;
    logic net_init;
    logic wr_a;
    logic wr_b;
    logic net_step;
    logic em_init;
    logic rd_emit;
    logic out_load;
    logic em_step;
  } oemn_cmd_t;

  typedef struct packed {
    logic load_last;
    logic swap;
    logic net_last;
    logic em_last;
    logic out_taken;
  } oemn_stat_t;

  // Clamp the raw size register to a supported log2 set size.
  function automatic logic [CFG_W-1:0] eff_log2(input logic [CFG_W-1:0] raw);
    logic [CFG_W-1:0] lg;
    lg = raw;
    if (raw == '0) begin
      lg = CFG_W'(1);
    end else if (raw > CFG_W'(LOG2_MAX)) begin
      lg = CFG_W'(LOG2_MAX);
    end
    return lg;
  endfunction

endpackage
`default_nettype wire

/* hdl/oemn_ram.sv */
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module oemn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

/* hdl/oemn_dpath.sv */
// Datapath: key store, size register, load/network/emit counters, output register.
`timescale 1ns / 1ps
`default_nettype none
module oemn_dpath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr,
  input  wire logic [oemn_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic [oemn_pkg::KEY_WIDTH-1:0]  key,
  input  wire logic                            out_stall,
  input  wire oemn_pkg::oemn_cmd_t             cmd,
  output oemn_pkg::oemn_stat_t                 stat,
  output logic                                 out_valid,
  output logic      [oemn_pkg::KEY_WIDTH-1:0]  merged_key,
  output logic                                 last_key
);
  import oemn_pkg::*;

  logic [CFG_W-1:0]     size_lg;
  logic [ADDR_W-1:0]    load_count;
  logic [ADDR_W-1:0]    k;
  logic [ADDR_W-1:0]    j;
  logic [ADDR_W-1:0]    i;
  logic [ADDR_W-1:0]    e;
  logic [KEY_WIDTH-1:0] hold;

  logic [CNT_W-1:0]     n;
  logic [ADDR_W-1:0]    half;
  logic [ADDR_W-1:0]    n_m1;
  logic [SUM_W-1:0]     a_sum;
  logic [SUM_W-1:0]     b_sum;
  logic [SUM_W-1:0]     j_3k;
  logic                 seg_end;
  logic                 pass_end;
  logic [ADDR_W-1:0]    addr_a;
  logic [ADDR_W-1:0]    addr_b;

  logic                 we;
  logic [ADDR_W-1:0]    waddr;
  logic [KEY_WIDTH-1:0] wdata;
  logic [ADDR_W-1:0]    raddr_a;
  logic [KEY_WIDTH-1:0] rdata_a;
  logic [KEY_WIDTH-1:0] rdata_b;

  assign n    = CNT_W'(1) << eff_log2(size_lg);
  assign half = ADDR_W'(n >> 1);
  assign n_m1 = ADDR_W'(n - CNT_W'(1));

  // Pair (j+i, j+i+k) of the current network pass
  assign a_sum    = SUM_W'(j) + SUM_W'(i);
  assign b_sum    = a_sum + SUM_W'(k);
  assign addr_a   = a_sum[ADDR_W-1:0];
  assign addr_b   = b_sum[ADDR_W-1:0];
  assign j_3k     = SUM_W'(j) + SUM_W'(k) + SUM_W'(k) + SUM_W'(k);
  assign seg_end  = (SUM_W'(i) + SUM_W'(1)) == SUM_W'(k);
  assign pass_end = seg_end && (j_3k >= SUM_W'(n));

  assign stat.load_last = (load_count == n_m1);
  assign stat.swap      = (rdata_b < rdata_a);
  assign stat.net_last  = pass_end && (k == ADDR_W'(1));
  assign stat.em_last   = (e == n_m1);
  assign stat.out_taken = out_valid && !out_stall;

  always_comb begin
    we      = cmd.load_wr || cmd.wr_a || cmd.wr_b;
    waddr   = addr_b;
    wdata   = hold;
    if (cmd.load_wr) begin
      waddr = load_count;
      wdata = key;
    end else if (cmd.wr_a) begin
      waddr = addr_a;
      wdata = rdata_b;
    end
    raddr_a = cmd.rd_emit ? e : addr_a;
  end

  oemn_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (addr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      size_lg    <= SIZE_LOG2_RESET;
      load_count <= '0;
      k          <= '0;
      j          <= '0;
      i          <= '0;
      e          <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        size_lg    <= cfg_data;
        load_count <= '0;
      end else if (cmd.load_wr) begin
        load_count <= stat.load_last ? '0 : load_count + ADDR_W'(1);
      end

      if (cmd.net_init) begin
        k <= half;
        j <= '0;
        i <= '0;
      end else if (cmd.net_step) begin
        if (seg_end) begin
          i <= '0;
          if (pass_end) begin
            k <= k >> 1;
            j <= k >> 1;
          end else begin
            j <= ADDR_W'(SUM_W'(j) + SUM_W'(k) + SUM_W'(k));
          end
        end else begin
          i <= i + ADDR_W'(1);
        end
      end

      if (cmd.em_init) begin
        e <= '0;
      end else if (cmd.em_step) begin
        e <= e + ADDR_W'(1);
      end

      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      hold <= rdata_a;
    end
    if (cmd.out_load) begin
      merged_key <= rdata_a;
      last_key   <= stat.em_last;
    end
  end

endmodule
`default_nettype wire

/* hdl/oemn_ctrl.sv */
// Controller: sequences load, compare-exchange passes and emit.
`timescale 1ns / 1ps
`default_nettype none
module oemn_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire oemn_pkg::oemn_stat_t stat,
  output logic                      in_stall,
  output oemn_pkg::oemn_cmd_t       cmd
);
  import oemn_pkg::*;

  oemn_state_t state;
  oemn_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != ST_LOAD);
    unique case (state)
      ST_LOAD: begin
        if (in_valid) begin
          cmd.load_wr = 1'b1;
          if (stat.load_last) begin
            cmd.net_init = 1'b1;
            state_next   = ST_CX_RD;
          end
        end
      end
      ST_CX_RD: begin
        state_next = ST_CX_CMP;
      end
      ST_CX_CMP: begin
        if (stat.swap) begin
          cmd.wr_a   = 1'b1;
          state_next = ST_CX_WB;
        end else begin
          cmd.net_step = 1'b1;
          if (stat.net_last) begin
            cmd.em_init = 1'b1;
            state_next  = ST_EM_RD;
          end else begin
            state_next = ST_CX_RD;
          end
        end
      end
      ST_CX_WB: begin
        cmd.wr_b     = 1'b1;
        cmd.net_step = 1'b1;
        if (stat.net_last) begin
          cmd.em_init = 1'b1;
          state_next  = ST_EM_RD;
        end else begin
          state_next = ST_CX_RD;
        end
      end
      ST_EM_RD: begin
        cmd.rd_emit = 1'b1;
        state_next  = ST_EM_LOAD;
      end
      ST_EM_LOAD: begin
        cmd.out_load = 1'b1;
        state_next   = ST_EM_HOLD;
      end
      ST_EM_HOLD: begin
        if (stat.out_taken) begin
          if (stat.em_last) begin
            state_next = ST_LOAD;
          end else begin
            cmd.em_step = 1'b1;
            state_next  = ST_EM_RD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hdl/odd_even_merge_network_unit.sv */
// Top level of the odd-even merge network unit.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------
//  cfg     | in        | cfg_valid / cfg_ready  | size_log2 [2:0]
//  in      | in        | in_valid / in_stall    | key [15:0]
//  out     | out       | out_valid / out_stall  | merged_key [15:0], last_key
//
// A set of n = 2^size_log2 keys (size_log2 clamped to 1..4) loads at one key
// per cycle while in_stall is low. The merge network then runs over the
// single-write key store: each compare-exchange reads its pair (ST_CX_RD)
// and compares it (ST_CX_CMP); a pair that swaps also takes ST_CX_WB (the
// store has one write port, so a swap writes its two keys in turn). Each
// merged key then passes through store read, output register load and
// transfer, and waits while out_stall is held.
// Reset (rst, synchronous) restores size_log2 to 4 and empties the load
// count; the key store is not cleared. in_stall stays high from the last
// key of a set until the last merged key of that set is transferred.
`timescale 1ns / 1ps
`default_nettype none
module odd_even_merge_network_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [oemn_pkg::CFG_W-1:0]      size_log2,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [oemn_pkg::KEY_WIDTH-1:0]  key,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [oemn_pkg::KEY_WIDTH-1:0]  merged_key,
  output logic                                 last_key
);
  import oemn_pkg::*;

  oemn_cmd_t  cmd;
  oemn_stat_t stat;
  logic       cfg_wr;

  // Always take the register write; it drops any partial set.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  oemn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  oemn_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_wr),
    .cfg_data   (size_log2),
    .key        (key),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .merged_key (merged_key),
    .last_key   (last_key)
  );

endmodule
`default_nettype wire

/* hdl/oemn_chk.sv */
// Port-level checker for the odd-even merge network unit, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module oemn_chk (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire logic [oemn_pkg::KEY_WIDTH-1:0]  key,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [oemn_pkg::KEY_WIDTH-1:0]  merged_key,
  input wire logic                            last_key
);

  // A stalled key offer holds until it transfers.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(key))
    else $error("stalled key changed");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(merged_key) && $stable(last_key))
    else $error("stalled result changed");

  // No key is taken while a merged key waits.
  a_no_load_during_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  // The last key of a set ends the output burst.
  a_last_ends_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_key |=> !out_valid)
    else $error("result after last key");

  // Reset leaves no result pending and the input open.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind odd_even_merge_network_unit oemn_chk u_oemn_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .key        (key),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .merged_key (merged_key),
  .last_key   (last_key)
);
`default_nettype wire

/* bench/oemn_checker.sv */
// Checker for the odd-even merge network unit: predicts merged sets and compares them.
`timescale 1ns / 1ps
module oemn_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [oemn_pkg::CFG_W-1:0]      size_log2,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [oemn_pkg::KEY_WIDTH-1:0]  key,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [oemn_pkg::KEY_WIDTH-1:0]  merged_key,
  input  logic                            last_key,
  output int                              fail_count,
  output int                              pending,
  output int                              result_count,
  output int                              set_count
);
  import oemn_pkg::*;

  typedef struct packed {
    logic [KEY_WIDTH-1:0] key;
    logic                 last;
  } merged_t;

  merged_t              merged_q [$];
  logic [KEY_WIDTH-1:0] set_buf [MAX_ITEMS];
  logic [CFG_W-1:0]     size_reg = SIZE_LOG2_RESET;
  int                   load_cnt = 0;
  int                   fails = 0;
  int                   results = 0;
  int                   sets = 0;

  assign fail_count   = fails;
  assign pending      = merged_q.size();
  assign result_count = results;
  assign set_count    = sets;

  // Set length: raw size 0 counts as 1, large sizes saturate at the store depth.
  function automatic int set_len(input logic [CFG_W-1:0] lg);
    int n;
    n = 2;
    while (n < (1 << lg) && n < MAX_ITEMS) n = n * 2;
    return n;
  endfunction

  // Batcher odd-even merge over the first n entries of the set buffer.
  task automatic merge_set(input int n);
    int half, k, j, i;
    logic [KEY_WIDTH-1:0] t;
    half = n / 2;
    for (k = half; k > 0; k = k / 2) begin
      for (j = (k == half) ? 0 : k; j + k < n; j = j + 2 * k) begin
        for (i = 0; i < k; i++) begin
          if (j + i + k < n && set_buf[j + i + k] < set_buf[j + i]) begin
            t = set_buf[j + i];
            set_buf[j + i] = set_buf[j + i + k];
            set_buf[j + i + k] = t;
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    int n, i;
    merged_t want;
    if (rst) begin
      size_reg = SIZE_LOG2_RESET;
      load_cnt = 0;
      merged_q.delete();
    end else begin
      // a size write drops any partial set
      if (cfg_valid && cfg_ready) begin
        size_reg = size_log2;
        load_cnt = 0;
      end
      if (in_valid && !in_stall) begin
        n = set_len(size_reg);
        if (load_cnt >= n) load_cnt = 0;
        set_buf[load_cnt] = key;
        load_cnt++;
        if (load_cnt == n) begin
          merge_set(n);
          for (i = 0; i < n; i++) begin
            want.key  = set_buf[i];
            want.last = (i == n - 1);
            merged_q.push_back(want);
          end
          load_cnt = 0;
          sets++;
        end
      end
      if (out_valid && !out_stall) begin
        results++;
        if (merged_q.size() == 0) begin
          fails++;
          if (fails <= 30)
            $display("%0t: unexpected merged key %h (last %b)", $time, merged_key, last_key);
        end else begin
          want = merged_q.pop_front();
          if (merged_key !== want.key) begin
            fails++;
            if (fails <= 30)
              $display("%0t: merged_key expected %h actual %h", $time, want.key, merged_key);
          end
          if (last_key !== want.last) begin
            fails++;
            if (fails <= 30)
              $display("%0t: last_key expected %b actual %b", $time, want.last, last_key);
          end
        end
      end
    end
  end

endmodule

/* bench/testbench.sv */
// Top of the odd-even merge network unit bench: stimulus, idling and verdict.
`timescale 1ns / 1ps
module testbench;
  import oemn_pkg::*;

  localparam int LIMIT        = 400000;  // cycles before the run is declared hung
  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam int SETTLE       = 8;       // cycles after the last result before a size write
  localparam int TARGET_ITEMS = 230;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     size_log2;
  logic                 in_valid;
  logic                 in_stall;
  logic [KEY_WIDTH-1:0] key;
  logic                 out_valid;
  logic                 out_stall;
  logic [KEY_WIDTH-1:0] merged_key;
  logic                 last_key;

  int fail_count, pending, result_count, set_count;
  int cycles;
  int sent = 0;        // accepted key transfers
  int writes = 0;      // accepted size writes
  int hold_seq = 0;    // bump to request one long receiver hold-off
  logic quiet = 1'b0;  // no idling on either side while set

  logic [KEY_WIDTH-1:0] set_keys [MAX_ITEMS];

  odd_even_merge_network_unit uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .size_log2  (size_log2),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .key        (key),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .merged_key (merged_key),
    .last_key   (last_key)
  );

  oemn_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .size_log2    (size_log2),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .key          (key),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .merged_key   (merged_key),
    .last_key     (last_key),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count),
    .set_count    (set_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one key and hold it until the transfer. Signals are read right
  // after the edge, so they still show the values the edge sampled. Valid
  // is left high so a following key goes out back to back.
  task automatic send_key(input logic [KEY_WIDTH-1:0] k);
    in_valid <= 1'b1;
    key      <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Send the first n entries of set_keys with random gaps between keys.
  task automatic send_set(input int n);
    int i, g;
    for (i = 0; i < n; i++) begin
      send_key(set_keys[i]);
      g = quiet ? 0 : idle_len();
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  // Wait until every merged key has come out, let the block settle back to
  // loading, then write the size register. The caller has dropped in_valid.
  // Step one edge first so the checker has counted the last key transfer.
  task automatic write_size(input logic [CFG_W-1:0] v);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    size_log2 <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    writes++;
  endtask

  // Insertion sort of set_keys[lo .. lo+cnt-1], ascending.
  task automatic sort_range(input int lo, input int cnt);
    logic [KEY_WIDTH-1:0] t;
    int a, b;
    for (a = lo + 1; a < lo + cnt; a++) begin
      t = set_keys[a];
      b = a - 1;
      while (b >= lo && set_keys[b] > t) begin
        set_keys[b + 1] = set_keys[b];
        b--;
      end
      set_keys[b + 1] = t;
    end
  endtask

  // Receiver: one out_stall update per cycle. Alternate free runs with
  // stalls of random length; a hold-off request stalls for a long stretch
  // counted here, so the block backs up and stalls its input.
  initial begin : receiver
    int stall_left, free_left, hold_seen;
    stall_left = 0;
    free_left  = 0;
    hold_seen  = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen  = hold_seq;
        stall_left = HOLD_CYCLES;
        free_left  = 0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (quiet || free_left > 0) begin
        out_stall <= 1'b0;
        if (free_left > 0) free_left--;
      end else begin
        out_stall  <= 1'b0;
        free_left  = $urandom_range(0, 12);
        stall_left = idle_len();
      end
    end
  end

  // Watchdog: a correct run ends long before this.
  initial begin : watchdog
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("odd_even_merge_network_unit: mismatch");
    $finish;
  end

  initial begin : stimulus
    int phase, n, sets, s, i, mode, total_fail;
    logic [CFG_W-1:0] v;
    logic broken;

    // Known values on every input from time zero.
    rst       = 1'b1;
    cfg_valid = 1'b0;
    size_log2 = '0;
    in_valid  = 1'b0;
    key       = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Partial set at the reset size of 16, then a size write: the three
    // keys must be dropped, not merged into the next set.
    send_key(16'hFFFF);
    send_key(16'h0000);
    send_key(16'h1234);
    in_valid <= 1'b0;

    // Size 0 runs as size 1: pairs. A reversed pair swaps; equal keys stay.
    write_size(3'd0);
    set_keys[0] = 16'hFFFF; set_keys[1] = 16'h0000;
    send_set(2);
    set_keys[0] = 16'hAAAA; set_keys[1] = 16'hAAAA;
    send_set(2);
    in_valid <= 1'b0;

    // Sets of four: extremes in the halves, then an unsorted first half.
    write_size(3'd2);
    set_keys[0] = 16'hFFFF; set_keys[1] = 16'hFFFF;
    set_keys[2] = 16'h0000; set_keys[3] = 16'h0000;
    send_set(4);
    set_keys[0] = 16'd9; set_keys[1] = 16'd3;
    set_keys[2] = 16'd1; set_keys[3] = 16'd2;
    send_set(4);
    in_valid <= 1'b0;

    // One interleaved set of eight.
    write_size(3'd3);
    set_keys[0] = 16'h0000; set_keys[1] = 16'd3; set_keys[2] = 16'd5; set_keys[3] = 16'hFFFF;
    set_keys[4] = 16'd2;    set_keys[5] = 16'd4; set_keys[6] = 16'd6; set_keys[7] = 16'hFFFE;
    send_set(8);
    in_valid <= 1'b0;

    // Random phases: a new size each phase, first through a fixed plan that
    // hits both ends and the saturating values, then at random.
    phase = 0;
    while (sent < TARGET_ITEMS) begin
      case (phase)
        0:       v = 3'd4;
        1:       v = 3'd1;
        2:       v = 3'd7;
        3:       v = 3'd0;
        4:       v = 3'd3;
        5:       v = 3'd5;
        6:       v = 3'd2;
        7:       v = 3'd6;
        default: v = CFG_W'($urandom_range(0, 7));
      endcase
      write_size(v);

      n = 2;
      while (n < (1 << v) && n < MAX_ITEMS) n = n * 2;
      if (n == MAX_ITEMS) sets = $urandom_range(1, 2);
      else if (n == 8)    sets = $urandom_range(2, 3);
      else                sets = $urandom_range(3, 6);

      // Long receiver hold-off while the sender keeps offering a second set.
      if (phase == 2) begin
        sets = 2;
        hold_seq++;
      end
      quiet = (phase == 5);

      for (s = 0; s < sets; s++) begin
        broken = ($urandom_range(0, 99) < 15);
        mode   = $urandom_range(0, 9);
        for (i = 0; i < n; i++) begin
          if (mode < 6)
            set_keys[i] = KEY_WIDTH'($urandom_range(0, 65535));
          else if (mode < 8)
            set_keys[i] = KEY_WIDTH'($urandom_range(0, 5));  // many equal keys
          else if ($urandom_range(0, 1) == 1)
            set_keys[i] = 16'hFFFF - KEY_WIDTH'($urandom_range(0, 2));
          else
            set_keys[i] = KEY_WIDTH'($urandom_range(0, 2));
        end
        // Well-formed sets have both halves ascending; broken ones are left raw.
        if (!broken) begin
          sort_range(0, n / 2);
          sort_range(n / 2, n / 2);
        end
        send_set(n);
      end
      in_valid <= 1'b0;
      quiet = 1'b0;
      phase++;
    end

    // Drain: wait out every merged key, then keep watching for strays.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("run covered %0d key transfers in %0d merged sets over %0d size writes",
             sent, set_count, writes);
    $display("%0d merged keys checked, %0d left waiting", result_count, pending);

    total_fail = fail_count + ((pending != 0) ? 1 : 0);
    if (total_fail == 0)
      $display("odd_even_merge_network_unit: match");
    else
      $display("odd_even_merge_network_unit: mismatch");
    $finish;
  end

endmodule
